// ===== hw/rtl/mhr_pkg.sv =====
// ----------------------------------------------------------------------------
// mhr_pkg
// shared constants and types for the motion hold and report block
// ----------------------------------------------------------------------------
package mhr_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE_TICKS = 1'd1;

  localparam logic [CFG_W-1:0] HOLD_TICKS_RST      = 16'd500;
  localparam logic [CFG_W-1:0] KEEPALIVE_TICKS_RST = 16'd1000;

  // input kind carried on in_tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LINE = 1'b1;

  // result word bit positions
  localparam int OUT_REPORT_BIT = 0;
  localparam int OUT_MOTION_BIT = 1;

  typedef struct packed {
    logic motion_active;
    logic last_reported;
    logic ever_reported;
  } mhr_flags_t;

endpackage

// ===== hw/rtl/motion_hold_and_report.sv =====
// ----------------------------------------------------------------------------
// motion_hold_and_report
// qualifies a motion sensor line with an off-delay and flags motion reports
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser
// in_      in   [0] level, [7:1] zero       [0] mode (0 tick, 1 line change)
// out_     out  [0] report, [1] motion,     -
//               [7:2] zero
// cfg_     in   index 0 hold_ticks, index 1 keepalive_ticks
//
// one item per cycle; the result appears in the output register in the cycle
// after the item is accepted. state updates in the accept cycle, so items
// follow back to back. the input is stalled only while a result waits and
// out_tready is low. synchronous active-low reset clears state and loads
// the register defaults.
// ----------------------------------------------------------------------------
module motion_hold_and_report #(
  parameter int COUNT_WIDTH = mhr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [0] level
  input  logic                         in_tuser,   // [0] mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [0] report, [1] motion
  input  logic                         cfg_wr_en,
  input  logic [mhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mhr_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [mhr_pkg::CFG_W-1:0] hold_ticks_r;
  logic [mhr_pkg::CFG_W-1:0] keepalive_ticks_r;

  mhr_pkg::mhr_flags_t    flags_r, flags_nxt;
  logic [COUNT_WIDTH-1:0] hold_count_r, hold_count_nxt;
  logic [COUNT_WIDTH-1:0] since_report_r, since_report_nxt;
  logic                   report;

  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic [7:0]             out_word;
  logic                   in_fire;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  mhr_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .mode             (in_tuser),
    .level            (in_tdata[0]),
    .hold_ticks       (hold_ticks_r),
    .keepalive_ticks  (keepalive_ticks_r),
    .flags            (flags_r),
    .hold_count       (hold_count_r),
    .since_report     (since_report_r),
    .flags_nxt        (flags_nxt),
    .hold_count_nxt   (hold_count_nxt),
    .since_report_nxt (since_report_nxt),
    .report           (report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r      <= mhr_pkg::HOLD_TICKS_RST;
      keepalive_ticks_r <= mhr_pkg::KEEPALIVE_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mhr_pkg::REG_HOLD_TICKS:      hold_ticks_r      <= cfg_wdata;
        mhr_pkg::REG_KEEPALIVE_TICKS: keepalive_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r        <= '0;
      hold_count_r   <= '0;
      since_report_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        flags_r        <= flags_nxt;
        hold_count_r   <= hold_count_nxt;
        since_report_r <= since_report_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_comb begin
    out_word                          = '0;
    out_word[mhr_pkg::OUT_REPORT_BIT] = report;
    out_word[mhr_pkg::OUT_MOTION_BIT] = flags_nxt.motion_active;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_word;
    end
  end

`ifndef SYNTH
  a_first_sets_ever: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> flags_r.ever_reported)
    else $error("ever_reported not set after an item");

  a_motion_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tdata[mhr_pkg::OUT_MOTION_BIT] == flags_r.motion_active)
    else $error("reported motion differs from state");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && report |=> since_report_r == '0 &&
                          flags_r.last_reported == flags_r.motion_active)
    else $error("report did not reset keepalive state");

  a_hold_expires: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == mhr_pkg::MODE_TICK && flags_r.motion_active &&
    hold_count_r == COUNT_WIDTH'(1) |=> !flags_r.motion_active)
    else $error("motion did not clear at hold expiry");
`endif

endmodule

// ===== hw/rtl/mhr_core.sv =====
// ----------------------------------------------------------------------------
// mhr_core
// next-state and report logic for one tick or line item
// ----------------------------------------------------------------------------
module mhr_core #(
  parameter int COUNT_WIDTH = mhr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    mode,
  input  logic                    level,
  input  logic [mhr_pkg::CFG_W-1:0] hold_ticks,
  input  logic [mhr_pkg::CFG_W-1:0] keepalive_ticks,
  input  mhr_pkg::mhr_flags_t     flags,
  input  logic [COUNT_WIDTH-1:0]  hold_count,
  input  logic [COUNT_WIDTH-1:0]  since_report,
  output mhr_pkg::mhr_flags_t     flags_nxt,
  output logic [COUNT_WIDTH-1:0]  hold_count_nxt,
  output logic [COUNT_WIDTH-1:0]  since_report_nxt,
  output logic                    report
);

  localparam int CMP_W = (COUNT_WIDTH > mhr_pkg::CFG_W) ? COUNT_WIDTH : mhr_pkg::CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'(CNT_MAX);

  logic [CMP_W-1:0]       hold_ext;
  logic [CMP_W-1:0]       keep_ext;
  logic [CMP_W-1:0]       since_ext;
  logic [COUNT_WIDTH-1:0] hold_load;
  logic                   motion;
  logic [COUNT_WIDTH-1:0] hold_upd;
  logic [COUNT_WIDTH-1:0] since_upd;

  assign hold_ext  = CMP_W'(hold_ticks);
  assign keep_ext  = CMP_W'(keepalive_ticks);
  // saturate the load when the counter is narrower than the register
  assign hold_load = (hold_ext > CNT_MAX_EXT) ? CNT_MAX : hold_ext[COUNT_WIDTH-1:0];

  always_comb begin
    motion    = flags.motion_active;
    hold_upd  = hold_count;
    since_upd = since_report;
    if (mode == mhr_pkg::MODE_LINE) begin
      if (level) begin
        motion   = 1'b1;
        hold_upd = '0;
      end else begin
        hold_upd = hold_load;
      end
    end else begin
      if (since_report != CNT_MAX) begin
        since_upd = since_report + 1'b1;
      end
      if (flags.motion_active && (hold_count != '0)) begin
        hold_upd = hold_count - 1'b1;
        if (hold_count == COUNT_WIDTH'(1)) begin
          motion = 1'b0;
        end
      end
    end
  end

  assign since_ext = CMP_W'(since_upd);
  assign report    = !flags.ever_reported || (motion != flags.last_reported) ||
                     ((keepalive_ticks != '0) && (since_ext >= keep_ext));

  always_comb begin
    flags_nxt.motion_active = motion;
    flags_nxt.last_reported = report ? motion : flags.last_reported;
    flags_nxt.ever_reported = flags.ever_reported | report;
    hold_count_nxt          = hold_upd;
    since_report_nxt        = report ? '0 : since_upd;
  end

endmodule

// ===== dv/motion_hold_and_report_tb.sv =====
// ----------------------------------------------------------------------------
// motion_hold_and_report_tb
// self-checking bench: tick and line-change words go in, the report and
// motion bits coming out are checked against an in-bench model of the
// off-delay and keepalive logic, over directed corners, a tick run with
// repeats disabled, and random phases with varied registers
// ----------------------------------------------------------------------------
module motion_hold_and_report_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = mhr_pkg::COUNT_WIDTH_DEF;

  typedef struct packed {
    logic report;
    logic motion;
  } motion_result_t;

  class motion_scoreboard;
    logic [mhr_pkg::CFG_W-1:0] hold_ticks;
    logic [mhr_pkg::CFG_W-1:0] keepalive_ticks;
    logic             motion_on;
    logic             last_sent;
    logic             ever_sent;
    logic [CNT_W-1:0] hold_left;
    logic [CNT_W-1:0] ticks_since;
    motion_result_t   expected_q[$];
    int               errors;

    function new();
      hold_ticks      = mhr_pkg::HOLD_TICKS_RST;
      keepalive_ticks = mhr_pkg::KEEPALIVE_TICKS_RST;
      motion_on       = 1'b0;
      last_sent       = 1'b0;
      ever_sent       = 1'b0;
      hold_left       = '0;
      ticks_since     = '0;
      errors          = 0;
    endfunction

    function void set_reg(logic [mhr_pkg::CFG_IDX_W-1:0] idx,
                          logic [mhr_pkg::CFG_W-1:0] val);
      if (idx == mhr_pkg::REG_HOLD_TICKS) begin
        hold_ticks = val;
      end else if (idx == mhr_pkg::REG_KEEPALIVE_TICKS) begin
        keepalive_ticks = val;
      end
    endfunction

    // advance the model by one accepted input word and queue its result
    function void note_item(logic mode, logic level);
      motion_result_t r;
      if (mode == mhr_pkg::MODE_LINE) begin
        if (level) begin
          motion_on = 1'b1;
          hold_left = '0;
        end else begin
          hold_left = hold_ticks;
        end
      end else begin
        if (ticks_since != '1) ticks_since = ticks_since + 1'b1;
        if (motion_on && hold_left != '0) begin
          hold_left = hold_left - 1'b1;
          if (hold_left == '0) motion_on = 1'b0;
        end
      end
      r.report = !ever_sent || (motion_on != last_sent) ||
                 (keepalive_ticks != '0 && ticks_since >= keepalive_ticks);
      if (r.report) begin
        ticks_since = '0;
        last_sent   = motion_on;
        ever_sent   = 1'b1;
      end
      r.motion = motion_on;
      expected_q.push_back(r);
    endfunction

    function void check_word(logic [7:0] word);
      motion_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", word);
      end else begin
        e = expected_q.pop_front();
        if (word[mhr_pkg::OUT_REPORT_BIT] !== e.report ||
            word[mhr_pkg::OUT_MOTION_BIT] !== e.motion) begin
          errors++;
          if (errors <= 10) begin
            $display("result mismatch: expected report %b motion %b, got report %b motion %b",
                     e.report, e.motion, word[mhr_pkg::OUT_REPORT_BIT],
                     word[mhr_pkg::OUT_MOTION_BIT]);
          end
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [7:0]                    in_tdata;   // [0] level
  logic                          in_tuser;   // [0] mode
  logic                          out_tvalid;
  logic                          out_tready;
  logic [7:0]                    out_tdata;  // [0] report, [1] motion
  logic                          cfg_wr_en;
  logic [mhr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mhr_pkg::CFG_W-1:0]     cfg_wdata;

  motion_scoreboard sb = new();

  bit calm = 1'b0;        // no idling on either side
  bit rx_hold_req = 1'b0;
  int tx_quiet = 0;
  logic [mhr_pkg::CFG_W-1:0] cur_hold = mhr_pkg::HOLD_TICKS_RST;

  motion_hold_and_report dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata[0]);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // receiver: random stall bursts, ready stretches, and one long hold-off
  initial begin
    int rx_gap;
    int rx_run;
    rx_gap = 0;
    rx_run = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_gap = 300;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (rx_run > 0) begin
        rx_run--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        rx_gap = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        rx_run = $urandom_range(1, 60);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("motion_hold_and_report: mismatch");
    $finish;
  end

  task automatic send_item(logic mode, logic level);
    int n;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (tx_quiet > 0) begin
      tx_quiet--;
    end else if (!calm) begin
      n = $urandom_range(1, 11);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
      tx_quiet = $urandom_range(0, 40);
    end
  endtask

  // stop sending and wait for every queued result to come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [mhr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mhr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    if (idx == mhr_pkg::REG_HOLD_TICKS) cur_hold = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_items(int count);
    int n;
    int k;
    int tail;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(($urandom_range(0, 3) == 0) ? mhr_pkg::MODE_LINE : mhr_pkg::MODE_TICK,
                  1'($urandom_range(0, 1)));
        n++;
      end else begin
        // motion on, line falls, then up to four ticks past the hold length, at most 40
        tail = (cur_hold < 36) ? cur_hold + 4 : 40;
        k = $urandom_range(0, tail);
        send_item(mhr_pkg::MODE_LINE, 1'b1);
        send_item(mhr_pkg::MODE_LINE, 1'b0);
        repeat (k) send_item(mhr_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
        n += k + 2;
      end
    end
  endtask

  initial begin
    int ph;
    logic [mhr_pkg::CFG_W-1:0] hv;
    logic [mhr_pkg::CFG_W-1:0] kv;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = mhr_pkg::MODE_TICK;
    cfg_wr_en = 1'b0;
    cfg_index = mhr_pkg::REG_HOLD_TICKS;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults: first word reports, rise, repeated rise, fall, rise
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    send_item(mhr_pkg::MODE_LINE, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b1);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    drain_results();

    // short hold expires, fall while idle does not count down, keepalive fires
    write_reg(mhr_pkg::REG_HOLD_TICKS, 16'd2);
    write_reg(mhr_pkg::REG_KEEPALIVE_TICKS, 16'd3);
    send_item(mhr_pkg::MODE_LINE, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b1);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_LINE, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    drain_results();

    // zero hold keeps motion on; repeats disabled
    write_reg(mhr_pkg::REG_HOLD_TICKS, 16'd0);
    write_reg(mhr_pkg::REG_KEEPALIVE_TICKS, 16'd0);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    send_item(mhr_pkg::MODE_LINE, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_LINE, 1'b1);
    send_item(mhr_pkg::MODE_LINE, 1'b0);

    // quiet tick run with repeats disabled
    calm = 1'b1;
    repeat (20) send_item(mhr_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
    drain_results();
    write_reg(mhr_pkg::REG_HOLD_TICKS, 16'hffff);
    write_reg(mhr_pkg::REG_KEEPALIVE_TICKS, 16'hffff);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_LINE, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b0);
    send_item(mhr_pkg::MODE_TICK, 1'b1);
    calm = 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       hv = 16'd1;
        1:       hv = 16'hffff;
        5:       hv = mhr_pkg::CFG_W'($urandom_range(13, 300));
        default: hv = mhr_pkg::CFG_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       kv = 16'd0;
        1:       kv = 16'd60000;
        5:       kv = mhr_pkg::CFG_W'($urandom_range(31, 200));
        default: kv = mhr_pkg::CFG_W'($urandom_range(1, 30));
      endcase
      if (ph == 0) begin
        hv = 16'd1;
        kv = 16'd60000;
      end
      write_reg(mhr_pkg::REG_HOLD_TICKS, hv);
      write_reg(mhr_pkg::REG_KEEPALIVE_TICKS, kv);
      if (ph == 1) rx_hold_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      random_items(100);
      if (ph == 2) drain_results();
      random_items(100);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("motion_hold_and_report: match");
    end else begin
      $display("motion_hold_and_report: mismatch");
    end
    $finish;
  end

endmodule
